// ----- rtl/core/ukmst_pkg.sv -----
// Package for the unique-key min-score record table.
// Holds widths, depth, status and opcode codes and the stored slot layout.
// No dependencies.
package ukmst_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KEY_W   = 31;
  localparam int SCORE_W = 10;
  localparam int ID_W    = 16;

  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
  } slot_t;

endpackage

// ----- rtl/core/ukmst_if.sv -----
// Channel interfaces for the record table: request beats in, result beats out.
// Depends on ukmst_pkg for field widths.
interface ukmst_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [ukmst_pkg::KEY_W-1:0]   key_number;
  logic [ukmst_pkg::SCORE_W-1:0] score;

  modport source (output valid, op, key_number, score, input ready);
  modport sink   (input valid, op, key_number, score, output ready);
endinterface

interface ukmst_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [ukmst_pkg::ID_W-1:0]    record_id;
  logic [ukmst_pkg::KEY_W-1:0]   record_key;
  logic [ukmst_pkg::SCORE_W-1:0] record_score;

  modport source (output valid, status, record_id, record_key, record_score, input ready);
  modport sink   (input valid, status, record_id, record_key, record_score, output ready);
endinterface

// ----- rtl/core/unique_key_min_score_table_top.sv -----
// Unique-key record table with remove-minimum, built around a single slot memory scan.
// Depends on ukmst_pkg and the channel interfaces in ukmst_if.sv.
//
// Usage:
//   in_chan carries one request per beat: op (insert or remove-minimum), key_number, score.
//   out_chan returns exactly one result beat per request: status, record_id,
//   record_key, record_score. Rejected inserts and empty removes return zero fields.
// Timing:
//   Each request walks every slot of the table memory once, one read per cycle,
//   with the compare logic working on the registered read data in the cycle after the read.
//   in_chan.ready is high only in the idle state, so a new request is accepted
//   only after the previous one has finished its scan and moved its result into
//   the result register; the single read port of the slot memory serializes them.
// Reset:
//   rst_n (synchronous, active low) clears every slot valid bit and the
//   result valid bit; the table is empty and ready right after reset.
// Stall:
//   A finished result waits in the output register; the next request is accepted
//   meanwhile and scanned, and its result is held back until out_chan.ready frees
//   the register.
module unique_key_min_score_table_top (
  input  logic               clk,
  input  logic               rst_n,
  ukmst_in_if.sink           in_chan,
  ukmst_out_if.source        out_chan
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                         state_r;
  logic [ukmst_pkg::DEPTH-1:0]    valid_r;
  logic [ukmst_pkg::CNT_W-1:0]    cnt_r;
  logic                           p_vld_r;
  logic [ukmst_pkg::IDX_W-1:0]    p_idx_r;

  logic                           op_r;
  logic [ukmst_pkg::KEY_W-1:0]    key_r;
  logic [ukmst_pkg::SCORE_W-1:0]  score_r;

  logic                           dup_r;
  logic                           any_r;
  logic [ukmst_pkg::ID_W-1:0]     newest_r;
  logic                           free_found_r;
  logic [ukmst_pkg::IDX_W-1:0]    free_idx_r;
  logic                           best_found_r;
  logic [ukmst_pkg::IDX_W-1:0]    best_idx_r;
  ukmst_pkg::slot_t               best_r;

  logic                           out_valid_r;
  logic [1:0]                     out_status_r;
  logic [ukmst_pkg::ID_W-1:0]     out_id_r;
  logic [ukmst_pkg::KEY_W-1:0]    out_key_r;
  logic [ukmst_pkg::SCORE_W-1:0]  out_score_r;

  ukmst_pkg::slot_t               mem [ukmst_pkg::DEPTH];
  ukmst_pkg::slot_t               rd_data_r;
  ukmst_pkg::slot_t               wr_data;
  logic                           mem_we;

  logic                           slot_live;
  logic                           better;
  logic                           out_free;
  logic                           ins_ok;
  ukmst_pkg::status_t             res_status;
  logic [ukmst_pkg::ID_W-1:0]     res_id;
  logic [ukmst_pkg::KEY_W-1:0]    res_key;
  logic [ukmst_pkg::SCORE_W-1:0]  res_score;
  logic [ukmst_pkg::ID_W-1:0]     new_id;

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.record_id    = out_id_r;
  assign out_chan.record_key   = out_key_r;
  assign out_chan.record_score = out_score_r;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign slot_live = p_vld_r && valid_r[p_idx_r];

  // Lower score wins; equal score goes to the older (smaller) id.
  assign better = !best_found_r ||
                  (rd_data_r.score < best_r.score) ||
                  ((rd_data_r.score == best_r.score) && (rd_data_r.id < best_r.id));

  assign new_id = any_r ? (newest_r + ukmst_pkg::ID_W'(1)) : '0;
  assign ins_ok = !dup_r && free_found_r && !(any_r && (newest_r == ukmst_pkg::ID_MAX));

  always_comb begin
    res_status = ukmst_pkg::ST_OK;
    res_id     = '0;
    res_key    = '0;
    res_score  = '0;
    if (op_r == ukmst_pkg::OP_INSERT) begin
      priority if (dup_r) begin
        res_status = ukmst_pkg::ST_DUP;
      end else if (!ins_ok) begin
        res_status = ukmst_pkg::ST_FULL;
      end else begin
        res_id    = new_id;
        res_key   = key_r;
        res_score = score_r;
      end
    end else if (!best_found_r) begin
      res_status = ukmst_pkg::ST_EMPTY;
    end else begin
      res_id    = best_r.id;
      res_key   = best_r.key;
      res_score = best_r.score;
    end
  end

  assign mem_we        = (state_r == S_DONE) && out_free &&
                         (op_r == ukmst_pkg::OP_INSERT) && ins_ok;
  assign wr_data.key   = key_r;
  assign wr_data.score = score_r;
  assign wr_data.id    = new_id;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_idx_r] <= wr_data;
    end
    rd_data_r <= mem[cnt_r[ukmst_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a taken beat; the done state reloads the register on its own.
      if (out_valid_r && out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r         <= in_chan.op;
            key_r        <= in_chan.key_number;
            score_r      <= in_chan.score;
            cnt_r        <= '0;
            p_vld_r      <= 1'b0;
            dup_r        <= 1'b0;
            any_r        <= 1'b0;
            free_found_r <= 1'b0;
            best_found_r <= 1'b0;
            state_r      <= S_SCAN;
          end
        end

        S_SCAN: begin
          // Issue the read for cnt_r, evaluate the slot read last cycle.
          p_idx_r <= cnt_r[ukmst_pkg::IDX_W-1:0];
          if (cnt_r == ukmst_pkg::CNT_W'(ukmst_pkg::DEPTH)) begin
            p_vld_r <= 1'b0;
            state_r <= S_DONE;
          end else begin
            p_vld_r <= 1'b1;
            cnt_r   <= cnt_r + ukmst_pkg::CNT_W'(1);
          end

          if (slot_live) begin
            if (rd_data_r.key == key_r) begin
              dup_r <= 1'b1;
            end
            if (!any_r || (rd_data_r.id > newest_r)) begin
              newest_r <= rd_data_r.id;
            end
            any_r <= 1'b1;
            if (better) begin
              best_found_r <= 1'b1;
              best_idx_r   <= p_idx_r;
              best_r       <= rd_data_r;
            end
          end else if (p_vld_r && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= p_idx_r;
          end
        end

        S_DONE: begin
          // Hold here until the result register is free.
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status;
            out_id_r     <= res_id;
            out_key_r    <= res_key;
            out_score_r  <= res_score;
            if (mem_we) begin
              valid_r[free_idx_r] <= 1'b1;
            end else if ((op_r == ukmst_pkg::OP_REMOVE) && best_found_r) begin
              valid_r[best_idx_r] <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/ukmst_chk.sv -----
// Port-level checker for the record table, bound to its top level.
// Depends on ukmst_pkg for status codes and widths.
module ukmst_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic [ukmst_pkg::ID_W-1:0]    record_id,
  input logic [ukmst_pkg::KEY_W-1:0]   record_key,
  input logic [ukmst_pkg::SCORE_W-1:0] record_score
);

  // A result beat stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // A request occupies the scan; no back-to-back acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a scan is running");

  // Every status other than ok carries zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ukmst_pkg::ST_OK) |->
      (record_id == '0) && (record_key == '0) && (record_score == '0))
    else $error("rejected or empty result carries nonzero fields");

  // Reset empties the result register and leaves the block ready.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result valid or busy right after reset");

endmodule

bind unique_key_min_score_table_top ukmst_chk u_ukmst_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .record_id    (out_chan.record_id),
  .record_key   (out_chan.record_key),
  .record_score (out_chan.record_score)
);

// ----- tb/sv/ukmst_record_table_check.sv -----
// Shadow of the record table: watches request and result beats, predicts each result
// and compares it field by field with the oldest pending prediction.
// Depends on ukmst_pkg and the channel interfaces in ukmst_if.sv.
module ukmst_record_table_check import ukmst_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  ukmst_in_if   in_mon,
  ukmst_out_if  out_mon,
  output int    mismatches,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } table_result_t;

  logic          shadow_used [DEPTH];
  slot_t         shadow_slot [DEPTH];
  table_result_t pending_results [$];

  function automatic table_result_t apply_request(op_t op, logic [KEY_W-1:0] key,
                                                  logic [SCORE_W-1:0] score);
    table_result_t   res;
    int              free_idx;
    int              pick;
    logic            have_any;
    logic [ID_W-1:0] newest;
    res      = '0;
    free_idx = -1;
    pick     = -1;
    have_any = 1'b0;
    newest   = '0;
    if (op == OP_INSERT) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (shadow_used[i]) begin
          // duplicate wins over a full table
          if (shadow_slot[i].key == key) begin
            res.status = ST_DUP;
            return res;
          end
          if (!have_any || shadow_slot[i].id > newest) newest = shadow_slot[i].id;
          have_any = 1'b1;
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (free_idx < 0 || (have_any && newest == ID_MAX)) begin
        res.status = ST_FULL;
        return res;
      end
      shadow_used[free_idx]       = 1'b1;
      shadow_slot[free_idx].key   = key;
      shadow_slot[free_idx].score = score;
      shadow_slot[free_idx].id    = have_any ? newest + 1'b1 : '0;
      res.status = ST_OK;
      res.id     = shadow_slot[free_idx].id;
      res.key    = key;
      res.score  = score;
    end else begin
      // lowest score, oldest id on a tie
      for (int i = 0; i < DEPTH; i++) begin
        if (shadow_used[i] && (pick < 0 || shadow_slot[i].score < shadow_slot[pick].score ||
            (shadow_slot[i].score == shadow_slot[pick].score &&
             shadow_slot[i].id < shadow_slot[pick].id)))
          pick = i;
      end
      if (pick < 0) begin
        res.status = ST_EMPTY;
        return res;
      end
      shadow_used[pick] = 1'b0;
      res.status = ST_OK;
      res.id     = shadow_slot[pick].id;
      res.key    = shadow_slot[pick].key;
      res.score  = shadow_slot[pick].score;
    end
    return res;
  endfunction

  function automatic void check_field(string field, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) shadow_used[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual status %0d id %0d key %0d score %0d",
                   $time, out_mon.status, out_mon.record_id, out_mon.record_key,
                   out_mon.record_score);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("record_id", want.id, out_mon.record_id);
          check_field("record_key", want.key, out_mon.record_key);
          check_field("record_score", want.score, out_mon.record_score);
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_results.push_back(apply_request(op_t'(in_mon.op), in_mon.key_number,
                                                in_mon.score));
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/sv/unique_key_min_score_table_top_tb.sv -----
// Top of the record table bench: clock, reset, request stimulus and result back-pressure.
// Depends on ukmst_pkg, ukmst_if.sv, the table top and ukmst_record_table_check.
module unique_key_min_score_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ukmst_pkg::*;

  localparam logic [KEY_W-1:0] KEY_ALL = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   steady;
  int   beats_sent;
  int   mismatches;
  int   outstanding;

  logic [SCORE_W-1:0] tie_scores [4] = '{10'd0, 10'd1, 10'd1000, 10'd1023};

  ukmst_in_if  in_chan ();
  ukmst_out_if out_chan ();

  unique_key_min_score_table_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ukmst_record_table_check record_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'($urandom);
  endfunction

  function automatic logic [SCORE_W-1:0] rand_score();
    return SCORE_W'($urandom_range(0, 1023));
  endfunction

  task automatic send_beat(op_t op, logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.op         <= op;
    in_chan.key_number <= key;
    in_chan.score      <= score;
    do @(posedge clk); while (!in_chan.ready);
    beats_sent++;
  endtask

  task automatic add_record(logic [KEY_W-1:0] key, logic [SCORE_W-1:0] score);
    send_beat(OP_INSERT, key, score);
  endtask

  // key and score ride along with random content; the block ignores them
  task automatic pop_min();
    send_beat(OP_REMOVE, rand_key(), rand_score());
  endtask

  // result side: drop ready for a random draw_wait() gap before each beat
  initial begin
    int stall;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  initial begin
    int               random_start;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] key_base;
    in_chan.valid      <= 1'b0;
    in_chan.op         <= OP_INSERT;
    in_chan.key_number <= '0;
    in_chan.score      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty remove, field extremes, duplicate, ties, reuse after emptying
    pop_min();
    add_record('0, '0);
    add_record(KEY_ALL, 10'd1023);
    add_record('0, 10'd500);
    add_record(31'h2AAA_AAAA, 10'h155);
    add_record(31'h5555_5555, 10'h2AA);
    add_record(31'd7, '0);
    add_record(31'd8, 10'd1000);
    repeat (6) pop_min();
    pop_min();
    add_record('0, 10'd5);
    add_record(KEY_ALL, 10'd5);
    add_record(31'd7, 10'd4);
    repeat (4) pop_min();

    random_start = beats_sent;
    while (beats_sent - random_start < 450) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          // fill past capacity, retry a stored key while full, drain past empty
          first_key = rand_key();
          add_record(first_key, rand_score());
          repeat (DEPTH + 2) add_record(rand_key(), rand_score());
          add_record(first_key, rand_score());
          repeat (DEPTH + 3) pop_min();
        end
        1: begin
          // small key pool: duplicates and keys coming back after removal
          key_base = rand_key();
          repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 9) < 6)
              add_record(key_base ^ KEY_W'($urandom_range(0, 15)), rand_score());
            else
              pop_min();
          end
        end
        2: begin
          // few distinct scores so that ties resolve by id
          repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 9) < 6)
              add_record(rand_key(), tie_scores[$urandom_range(0, 3)]);
            else
              pop_min();
          end
        end
        default: begin
          repeat ($urandom_range(20, 60)) begin
            if ($urandom_range(0, 1) == 1) add_record(rand_key(), rand_score());
            else pop_min();
          end
        end
      endcase
    end
    steady = 1'b0;

    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ukmst_pkg.sv
rtl/core/ukmst_if.sv
rtl/core/unique_key_min_score_table_top.sv
rtl/core/ukmst_chk.sv
tb/sv/ukmst_record_table_check.sv
tb/sv/unique_key_min_score_table_top_tb.sv
